/* rtl/core/hld_pkg.sv */
// Shared constants and level status codes for the hierarchical loop detector.
`default_nettype none

package hld_pkg;

    // Parameter defaults
    localparam int WINDOW_MAX_DEF = 256;
    localparam int LEVELS_MAX_DEF = 4;

    // Fixed field widths
    localparam int SAMPLE_W  = 64;
    localparam int SIZE_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int GOV_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;
    localparam int LEVCFG_W  = 3;
    localparam int OUT_TDATA_W = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

    // Register reset values
    localparam logic [LEVCFG_W-1:0]  LEVELS_RST = 3'd4;
    localparam logic [CFG_DAT_W-1:0] WINDOW_RST = 9'd256;

    // Level status, with the codes of "none" and "end" swapped so that "end" is the lowest code
    localparam logic [2:0] ENC_END     = 3'd0;
    localparam logic [2:0] ENC_NONE    = 3'd1;
    localparam logic [2:0] ENC_IN      = 3'd2;
    localparam logic [2:0] ENC_ITER    = 3'd3;
    localparam logic [2:0] ENC_NEW     = 3'd4;
    localparam logic [2:0] ENC_END_NEW = 3'd5;

    // Reported status codes
    localparam logic [STATUS_W-1:0] STAT_NONE = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_END  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MAX  = 3'd5;

endpackage

`default_nettype wire

/* rtl/core/hld_mod_unit.sv */
// Bit-serial remainder unit: one quotient bit per cycle.
`default_nettype none

module hld_mod_unit #(
    parameter int DW = 32,
    parameter int VW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [VW-1:0]      o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [VW-1:0] r_dvs, n_dvs;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW:0]   w_tmp;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        w_tmp  = {r_rem, r_dvd[DW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_tmp >= {1'b0, r_dvs}) begin
                w_tmp = w_tmp - {1'b0, r_dvs};
            end
            n_rem = w_tmp[VW-1:0];
            n_dvd = {r_dvd[DW-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/core/hierarchical_loop_detector.sv */
// Top level of the hierarchical loop detector: rings, level sequencer and merge.
`default_nettype none

// Takes one 64-bit event code per input beat and returns one result beat with
// the loop status, the governing loop size and the governing level. Work is
// done one level at a time by a single sequencer over shared ring memories:
// each level walks its filled window entry by entry (read, then compare and
// run-count update), runs a serial remainder when a loop longer than one is
// found, and, when a level above level 0 reports a new loop, walks the entries
// of the found period to sum the iteration size. The input side is ready only
// in the idle state; a finished result sits in an output register so the next
// item may be accepted while it waits. After reset a clearing pass over all
// LEVELS_MAX*WINDOW_MAX entries (1024 by default) zeroes the run-count ring
// before the first item is taken. Configuration writes are taken in any cycle
// but must only be issued while the block is idle.
module hierarchical_loop_detector #(
    parameter int WINDOW_MAX = hld_pkg::WINDOW_MAX_DEF,
    parameter int LEVELS_MAX = hld_pkg::LEVELS_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream; tdata: event_code[63:0]
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [hld_pkg::SAMPLE_W-1:0]    i_s_axis_tdata,
    // result stream; tdata: loop_status[2:0], loop_size[34:3],
    // governing_level[36:35], zero fill[39:37]
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [hld_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hld_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hld_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int LW    = $clog2(WINDOW_MAX);          // ring index
    localparam int WW    = LW + 1;                      // window length
    localparam int LCW   = $clog2(LEVELS_MAX + 1);      // level count
    localparam int LVW   = (LEVELS_MAX > 1) ? $clog2(LEVELS_MAX) : 1;
    localparam int DEPTH = LEVELS_MAX * WINDOW_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = hld_pkg::SIZE_W;

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_ZB    = 4'd5;
    localparam logic [3:0] S_MOD   = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_ISR   = 4'd8;
    localparam logic [3:0] S_ISA   = 4'd9;
    localparam logic [3:0] S_MERGE = 4'd10;

    localparam logic [SW-1:0] SIZE_SAT = '1;

    function automatic logic [LW-1:0] f_next(input logic [LW-1:0] p,
                                             input logic [WW-1:0] w);
        logic [WW-1:0] q;
        q = {1'b0, p} + 1'b1;
        return (q >= w) ? '0 : q[LW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [LCW-1:0] lv,
                                             input logic [LW-1:0]  idx);
        logic [31:0] a;
        a = 32'(lv) * 32'(WINDOW_MAX) + 32'(idx);
        return a[AW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [hld_pkg::LEVCFG_W-1:0]  r_cfg_levels;
    logic [hld_pkg::CFG_DAT_W-1:0] r_cfg_window;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_levels <= hld_pkg::LEVELS_RST;
            r_cfg_window <= hld_pkg::WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hld_pkg::REG_LEVELS: r_cfg_levels <= i_cfg_data[hld_pkg::LEVCFG_W-1:0];
                hld_pkg::REG_WINDOW: r_cfg_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective window: multiple of 16, clamped to 16..WINDOW_MAX; effective levels clamped to 1..LEVELS_MAX
    logic [31:0]    w_win32;
    logic [WW-1:0]  w_eff_win;
    logic [31:0]    w_lev32;
    logic [LCW-1:0] w_eff_lev;

    always_comb begin
        w_win32 = {23'd0, r_cfg_window & 9'h1F0};
        if (w_win32 < 32'd16) w_win32 = 32'd16;
        if (w_win32 > 32'(WINDOW_MAX)) w_win32 = 32'(WINDOW_MAX);
        w_eff_win = w_win32[WW-1:0];
        w_lev32 = {29'd0, r_cfg_levels};
        if (w_lev32 == 32'd0) w_lev32 = 32'd1;
        if (w_lev32 > 32'(LEVELS_MAX)) w_lev32 = 32'(LEVELS_MAX);
        w_eff_lev = w_lev32[LCW-1:0];
    end

    // ---------------- ring memories ----------------
    logic [hld_pkg::SAMPLE_W-1:0] r_smp_mem [DEPTH];
    logic [SW-1:0]                r_siz_mem [DEPTH];
    logic [SW-1:0]                r_run_mem [DEPTH];

    logic                         w_sz_we;
    logic [AW-1:0]                w_sz_waddr, w_sz_raddr;
    logic                         w_run_we;
    logic [AW-1:0]                w_run_waddr, w_run_raddr;
    logic [SW-1:0]                w_run_wdata;
    logic [hld_pkg::SAMPLE_W-1:0] r_rd_smp;
    logic [SW-1:0]                r_rd_siz;
    logic [SW-1:0]                r_rd_run;

    // ---------------- sequencer state ----------------
    logic [3:0]                   r_state, n_state;
    logic [AW-1:0]                r_clr, n_clr;
    logic [hld_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic [SW-1:0]                r_size, n_size;
    logic [LCW-1:0]               r_lv, n_lv;
    logic [LCW-1:0]               r_reach, n_reach;
    logic [LCW-1:0]               r_nlev, n_nlev;
    logic [WW-1:0]                r_w, n_w;
    logic [LW-1:0]                r_pos, n_pos;
    logic [LW-1:0]                r_lim, n_lim;
    logic [LW-1:0]                r_a, n_a;
    logic [LW-1:0]                r_b, n_b;
    logic [LW-1:0]                r_k, n_k;
    logic [LW-1:0]                r_best_len, n_best_len;
    logic [SW-1:0]                r_best_run, n_best_run;
    logic                         r_mod_one, n_mod_one;
    logic [SW-1:0]                r_total, n_total;

    logic [LW-1:0] r_wpos  [LEVELS_MAX];
    logic [LW-1:0] r_flim  [LEVELS_MAX];
    logic [LW-1:0] r_held  [LEVELS_MAX];
    logic [LW-1:0] r_found [LEVELS_MAX];
    logic [2:0]    r_lstate [LEVELS_MAX];

    logic                         r_out_valid, n_out_valid;
    logic [hld_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [SW-1:0]                r_out_size, n_out_size;
    logic [hld_pkg::GOV_W-1:0]    r_out_gov, n_out_gov;

    // remainder unit
    logic          w_mod_start;
    logic          w_mod_done;
    logic [LW-1:0] w_mod_rem;

    hld_mod_unit #(
        .DW (SW),
        .VW (LW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_best_run),
        .i_divisor  (r_best_len),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // level-local views
    logic [LVW-1:0] w_li;
    logic [LW-1:0]  w_wm1;
    logic [LW-1:0]  w_cpos, w_clim, w_a0;
    logic           w_match;
    logic [SW-1:0]  w_run_inc;
    logic           w_in_loop, w_new_it, w_new_loop, w_ended;
    logic [2:0]     w_enc;
    logic [LW-1:0]  w_prev, w_prev_n;
    logic [LW-1:0]  w_npos, w_nlim;
    logic [WW-1:0]  w_p2;
    logic [LW-1:0]  w_isz_p;
    logic [SW:0]    w_sum;
    logic [LCW-1:0] w_lv_inc;

    // merge
    logic [2:0]                   w_clean [LEVELS_MAX];
    logic                         w_m_done, w_m_ended, w_m_stop;
    logic [2:0]                   w_m_enc, w_m_s;
    logic [SW-1:0]                w_m_size;
    logic [hld_pkg::GOV_W-1:0]    w_m_gov;
    logic [hld_pkg::STATUS_W-1:0] w_m_status;
    logic                         w_out_free;

    assign w_li  = r_lv[LVW-1:0];
    assign w_wm1 = LW'(r_w - 1'b1);

    always_comb begin
        w_cpos = ({1'b0, r_wpos[w_li]} >= r_w) ? w_wm1 : r_wpos[w_li];
        w_clim = (r_flim[w_li] > w_wm1) ? w_wm1 : r_flim[w_li];
        w_a0   = f_next(w_cpos, r_w);
    end

    assign w_match   = (r_rd_smp == r_sample) && (r_rd_siz == r_size);
    assign w_run_inc = (r_rd_run == SIZE_SAT) ? r_rd_run : r_rd_run + 1'b1;

    // status of the level that has just been scanned
    always_comb begin
        w_prev     = r_held[w_li];
        w_in_loop  = (r_best_len != '0) && (r_best_run > SW'(r_best_len));
        w_new_it   = w_in_loop && ((r_best_len == LW'(1)) || r_mod_one);
        w_new_loop = w_new_it && (w_prev != r_best_len);
        w_ended    = (w_prev != r_best_len) && (w_prev != '0);
        w_enc = hld_pkg::ENC_NONE - 3'(!w_in_loop && w_ended) + 3'(w_in_loop)
              + 3'(w_new_it) + 3'(w_new_loop) + 3'(w_new_loop && w_ended);
        if (w_enc >= hld_pkg::ENC_NEW)       w_prev_n = r_best_len;
        else if (w_enc <= hld_pkg::ENC_NONE) w_prev_n = '0;
        else                                 w_prev_n = w_prev;
        w_npos = (r_pos == '0) ? w_wm1 : r_pos - 1'b1;
        w_nlim = (r_lim >= w_wm1) ? w_wm1 : r_lim + 1'b1;
        w_p2   = {1'b0, w_npos} + WW'(2);
        w_isz_p = (w_p2 >= r_w) ? LW'(w_p2 - r_w) : w_p2[LW-1:0];
        w_sum  = {1'b0, r_total} + {1'b0, r_rd_siz};
        w_lv_inc = r_lv + 1'b1;
    end

    // clean levels above the reach, then merge from the top down
    always_comb begin
        for (int l = 0; l < LEVELS_MAX; l++) begin
            w_clean[l] = r_lstate[l];
            if (l < int'(r_nlev) && l > int'(r_reach)) begin
                if (r_lstate[l] > hld_pkg::ENC_IN)   w_clean[l] = hld_pkg::ENC_IN;
                if (r_lstate[l] < hld_pkg::ENC_NONE) w_clean[l] = hld_pkg::ENC_NONE;
            end
        end
        w_m_done  = 1'b0;
        w_m_ended = 1'b0;
        w_m_stop  = 1'b0;
        w_m_enc   = hld_pkg::ENC_NONE;
        w_m_size  = '0;
        w_m_gov   = '0;
        w_m_s     = hld_pkg::ENC_NONE;
        for (int l = LEVELS_MAX - 1; l >= 0; l--) begin
            if (!w_m_done && l < int'(r_nlev)) begin
                w_m_s = w_clean[l];
                w_m_ended = w_m_ended || (w_m_s == hld_pkg::ENC_END);
                if (w_m_s >= hld_pkg::ENC_IN) begin
                    w_m_done = 1'b1;
                    w_m_gov  = hld_pkg::GOV_W'(l);
                    w_m_size = SW'(r_found[l]);
                    if (w_m_ended) begin
                        w_m_enc = hld_pkg::ENC_END_NEW;
                    end else begin
                        w_m_enc = w_m_s;
                        if (w_m_s == hld_pkg::ENC_NEW) begin
                            for (int ll = LEVELS_MAX - 2; ll >= 0; ll--) begin
                                if (ll < l && !w_m_stop) begin
                                    w_m_ended = w_m_ended
                                              || (w_clean[ll] == hld_pkg::ENC_END_NEW);
                                    if (w_clean[ll] < hld_pkg::ENC_NEW) begin
                                        w_m_stop = 1'b1;
                                        w_m_enc  = hld_pkg::ENC_IN;
                                    end
                                end
                            end
                        end
                        if (!w_m_stop && w_m_ended) w_m_enc = hld_pkg::ENC_END_NEW;
                    end
                end
            end
        end
        if (!w_m_done) w_m_enc = w_m_ended ? hld_pkg::ENC_END : hld_pkg::ENC_NONE;
        case (w_m_enc)
            hld_pkg::ENC_END:  w_m_status = hld_pkg::STAT_END;
            hld_pkg::ENC_NONE: w_m_status = hld_pkg::STAT_NONE;
            default:           w_m_status = w_m_enc;
        endcase
    end

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_sample    = r_sample;
        n_size      = r_size;
        n_lv        = r_lv;
        n_reach     = r_reach;
        n_nlev      = r_nlev;
        n_w         = r_w;
        n_pos       = r_pos;
        n_lim       = r_lim;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_best_len  = r_best_len;
        n_best_run  = r_best_run;
        n_mod_one   = r_mod_one;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_status = r_out_status;
        n_out_size  = r_out_size;
        n_out_gov   = r_out_gov;
        w_sz_we     = 1'b0;
        w_sz_waddr  = f_addr(r_lv, w_cpos);
        w_sz_raddr  = f_addr(r_lv, r_a);
        w_run_we    = 1'b0;
        w_run_waddr = f_addr(r_lv, r_a);
        w_run_raddr = f_addr(r_lv, r_b);
        w_run_wdata = '0;
        w_mod_start = 1'b0;

        if (r_out_valid && i_m_axis_tready) n_out_valid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_run_we    = 1'b1;
                w_run_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_sample = i_s_axis_tdata;
                    n_size   = SW'(1);
                    n_lv     = '0;
                    n_w      = w_eff_win;
                    n_nlev   = w_eff_lev;
                    n_state  = S_START;
                end
            end
            S_START: begin
                // store the new sample at the write position, set up the scan
                w_sz_we    = 1'b1;
                n_pos      = w_cpos;
                n_lim      = w_clim;
                n_a        = w_a0;
                n_b        = f_next(w_a0, r_w);
                n_k        = LW'(1);
                n_best_len = '0;
                n_best_run = '0;
                n_mod_one  = 1'b0;
                n_state    = (w_clim == '0) ? S_EVAL : S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match) begin
                    w_run_we    = 1'b1;
                    w_run_wdata = w_run_inc;
                    if (w_run_inc > r_best_run && SW'(r_k) < w_run_inc) begin
                        n_best_len = r_k;
                        n_best_run = w_run_inc;
                    end
                end else if (r_k != LW'(1)) begin
                    w_run_we = 1'b1;    // clears the stale count left at this slot
                end
                if (r_k == r_lim) begin
                    n_state = S_ZB;
                end else begin
                    n_a     = r_b;
                    n_b     = f_next(r_b, r_w);
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_ZB: begin
                w_run_we    = 1'b1;
                w_run_waddr = f_addr(r_lv, r_b);
                if (r_best_len > LW'(1) && r_best_run > SW'(r_best_len)) begin
                    w_mod_start = 1'b1;
                    n_state     = S_MOD;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_mod_one = (w_mod_rem == LW'(1));
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_enc >= hld_pkg::ENC_NEW) begin
                    if (r_lv == '0) begin
                        n_size = SW'(r_best_len);
                        n_lv   = w_lv_inc;
                        if (w_lv_inc >= r_nlev) begin
                            n_reach = r_lv;
                            n_state = S_MERGE;
                        end else begin
                            n_state = S_START;
                        end
                    end else begin
                        n_a     = w_isz_p;
                        n_k     = '0;
                        n_total = '0;
                        n_state = S_ISR;
                    end
                end else begin
                    n_reach = r_lv;
                    n_state = S_MERGE;
                end
            end
            S_ISR: begin
                n_state = S_ISA;
            end
            S_ISA: begin
                n_total = w_sum[SW] ? SIZE_SAT : w_sum[SW-1:0];
                n_a     = f_next(r_a, r_w);
                n_k     = r_k + 1'b1;
                if (r_k + 1'b1 == r_best_len) begin
                    n_size = w_sum[SW] ? SIZE_SAT : w_sum[SW-1:0];
                    n_lv   = w_lv_inc;
                    if (w_lv_inc >= r_nlev) begin
                        n_reach = r_lv;
                        n_state = S_MERGE;
                    end else begin
                        n_state = S_START;
                    end
                end else begin
                    n_state = S_ISR;
                end
            end
            S_MERGE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = w_m_status;
                    n_out_size   = w_m_size;
                    n_out_gov    = w_m_gov;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_sz_we) begin
            r_smp_mem[w_sz_waddr] <= r_sample;
            r_siz_mem[w_sz_waddr] <= r_size;
        end
        r_rd_smp <= r_smp_mem[w_sz_raddr];
        r_rd_siz <= r_siz_mem[w_sz_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_run_we) r_run_mem[w_run_waddr] <= w_run_wdata;
        r_rd_run <= r_run_mem[w_run_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < LEVELS_MAX; l++) begin
                r_wpos[l]   <= '0;
                r_flim[l]   <= '0;
                r_held[l]   <= '0;
                r_found[l]  <= '0;
                r_lstate[l] <= hld_pkg::ENC_NONE;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (r_state == S_EVAL) begin
                r_found[w_li]  <= r_best_len;
                r_held[w_li]   <= w_prev_n;
                r_wpos[w_li]   <= w_npos;
                r_flim[w_li]   <= w_nlim;
                r_lstate[w_li] <= w_enc;
            end
            if (r_state == S_MERGE && w_out_free) begin
                for (int l = 0; l < LEVELS_MAX; l++) r_lstate[l] <= w_clean[l];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_sample     <= n_sample;
        r_size       <= n_size;
        r_lv         <= n_lv;
        r_reach      <= n_reach;
        r_nlev       <= n_nlev;
        r_w          <= n_w;
        r_pos        <= n_pos;
        r_lim        <= n_lim;
        r_a          <= n_a;
        r_b          <= n_b;
        r_k          <= n_k;
        r_best_len   <= n_best_len;
        r_best_run   <= n_best_run;
        r_mod_one    <= n_mod_one;
        r_total      <= n_total;
        r_out_status <= n_out_status;
        r_out_size   <= n_out_size;
        r_out_gov    <= n_out_gov;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out_gov, r_out_size, r_out_status};

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_START))
        else $error("accepted beat did not start a level scan");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k != '0 && r_k <= r_lim))
        else $error("scan step outside the filled window");

    a_mod_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder finished outside its wait state");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status <= hld_pkg::STAT_MAX))
        else $error("result status out of range");

    a_size_vs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_size == '0) == (r_out_status == hld_pkg::STAT_NONE
                                              || r_out_status == hld_pkg::STAT_END)))
        else $error("loop size disagrees with status");

endmodule

`default_nettype wire
